[rtl/core/rrtu_pkg.sv]
package rrtu_pkg;

    // table geometry and field widths
    localparam int FIELD_W     = 8;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OUT_IDX_W   = 6;

    typedef logic [FIELD_W-1:0]   t_field;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [OUT_IDX_W-1:0] t_out_idx;

    // probe word as it walks down the cell chain
    typedef struct packed {
        logic   vld;
        logic   done;
        logic   inserted;
        t_idx   idx;
        t_field node;
        t_field hops;
        t_field ring;
        t_field best_ring;
        t_field best_hops;
        t_field sec_ring;
        t_field sec_hops;
    } t_token;

    // low bits of a slot number as reported on the result word
    function automatic t_out_idx to_out_idx(input t_idx idx);
        logic [IDX_W+OUT_IDX_W-1:0] w_ext;
        w_ext = {{OUT_IDX_W{1'b0}}, idx};
        return w_ext[OUT_IDX_W-1:0];
    endfunction

endpackage

[rtl/core/rrtu_if.sv]
// probe record channel
interface rrtu_probe_if;
    logic                       valid;
    logic                       ready;
    logic [rrtu_pkg::FIELD_W-1:0] node_id;
    logic [rrtu_pkg::FIELD_W-1:0] hop_cnt;
    logic [rrtu_pkg::FIELD_W-1:0] ring_id;

    modport source (output valid, node_id, hop_cnt, ring_id, input ready);
    modport sink   (input valid, node_id, hop_cnt, ring_id, output ready);
endinterface

// updated entry channel
interface rrtu_result_if;
    logic                         valid;
    logic                         ready;
    logic                         inserted;
    logic                         dropped;
    logic [rrtu_pkg::OUT_IDX_W-1:0] entry_index;
    logic [rrtu_pkg::FIELD_W-1:0] best_ring;
    logic [rrtu_pkg::FIELD_W-1:0] best_hops;
    logic [rrtu_pkg::FIELD_W-1:0] second_ring;
    logic [rrtu_pkg::FIELD_W-1:0] second_hops;

    modport source (output valid, inserted, dropped, entry_index, best_ring, best_hops,
                    second_ring, second_hops, input ready);
    modport sink   (input valid, inserted, dropped, entry_index, best_ring, best_hops,
                    second_ring, second_hops, output ready);
endinterface

[rtl/core/rrtu_cell.sv]
module rrtu_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  rrtu_pkg::t_idx  i_idx,
    input  rrtu_pkg::t_token i_tok,
    output rrtu_pkg::t_token o_tok,
    output logic            o_occ
);
    import rrtu_pkg::*;

    logic   r_occ, n_occ;
    t_token r_tok, n_tok;
    t_field r_node, n_node;
    t_field r_ra, n_ra;
    t_field r_ha, n_ha;
    t_field r_rb, n_rb;
    t_field r_hb, n_hb;
    logic   w_live, w_hit, w_claim;

    assign w_live  = i_tok.vld && !i_tok.done;
    assign w_hit   = w_live && r_occ && (r_node == i_tok.node);
    assign w_claim = w_live && !r_occ;

    // match and merge, or claim this free slot
    always_comb begin
        n_tok  = i_tok;
        n_occ  = r_occ;
        n_node = r_node;
        n_ra   = r_ra;
        n_ha   = r_ha;
        n_rb   = r_rb;
        n_hb   = r_hb;
        if (w_hit) begin
            if (i_tok.hops <= r_ha) begin
                // old best demoted only when strictly better than second
                if (r_ha < r_hb) begin
                    n_rb = r_ra;
                    n_hb = r_ha;
                end
                n_ra = i_tok.ring;
                n_ha = i_tok.hops;
            end else if (i_tok.hops < r_hb) begin
                n_rb = i_tok.ring;
                n_hb = i_tok.hops;
            end else if ((i_tok.hops > r_hb) && (r_ra == r_rb)) begin
                n_rb = i_tok.ring;
                n_hb = i_tok.hops;
            end
        end else if (w_claim) begin
            n_occ  = 1'b1;
            n_node = i_tok.node;
            n_ra   = i_tok.ring;
            n_ha   = i_tok.hops;
            n_rb   = i_tok.ring;
            n_hb   = i_tok.hops;
        end
        if (w_hit || w_claim) begin
            n_tok.done      = 1'b1;
            n_tok.inserted  = w_claim;
            n_tok.idx       = i_idx;
            n_tok.best_ring = n_ra;
            n_tok.best_hops = n_ha;
            n_tok.sec_ring  = n_rb;
            n_tok.sec_hops  = n_hb;
        end
    end

    // entry state and word register, only control bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= 1'b0;
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_occ  <= n_occ;
            r_node <= n_node;
            r_ra   <= n_ra;
            r_ha   <= n_ha;
            r_rb   <= n_rb;
            r_hb   <= n_hb;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_occ = r_occ;

endmodule

[rtl/core/ring_route_table_update_top.sv]
// an accepted probe word passes through every entry cell of the chain, each one
// registering it, before it leaves as the result word
// throughput: one word per cycle; a stalled result freezes the whole chain
// reset clears the entry valid marks and the in-flight words; entry contents
// need no clearing, the block is ready right after reset
module ring_route_table_update_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrtu_probe_if.sink    i_probe,
    rrtu_result_if.source o_result
);
    import rrtu_pkg::*;

    t_token                 w_tok [TABLE_DEPTH+1];
    t_token                 w_head;
    logic [TABLE_DEPTH-1:0] w_occ;
    logic                   w_adv;
    t_token                 w_last;

    assign w_last = w_tok[TABLE_DEPTH];
    assign w_adv  = !w_last.vld || o_result.ready;
    assign i_probe.ready = w_adv;

    // word entering the chain
    always_comb begin
        w_head      = '0;
        w_head.vld  = i_probe.valid;
        w_head.node = i_probe.node_id;
        w_head.hops = i_probe.hop_cnt;
        w_head.ring = i_probe.ring_id;
    end

    assign w_tok[0] = w_head;

    // row of entry cells
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        rrtu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_idx   (IDX_W'(k)),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1]),
            .o_occ   (w_occ[k])
        );
    end

    // result word, zero fields on a drop
    assign o_result.valid       = w_last.vld;
    assign o_result.inserted    = w_last.done && w_last.inserted;
    assign o_result.dropped     = !w_last.done;
    assign o_result.entry_index = w_last.done ? to_out_idx(w_last.idx) : '0;
    assign o_result.best_ring   = w_last.done ? w_last.best_ring : '0;
    assign o_result.best_hops   = w_last.done ? w_last.best_hops : '0;
    assign o_result.second_ring = w_last.done ? w_last.sec_ring : '0;
    assign o_result.second_hops = w_last.done ? w_last.sec_hops : '0;

    // occupied slots always form a prefix of the table
    a_occ_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ >> 1) & ~w_occ) == '0)
        else $error("occupied slot above a free slot");

    // a drop only happens with every slot taken
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.dropped) |-> (&w_occ))
        else $error("drop reported while a slot is free");

    // a stalled chain keeps the table unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> $stable(w_occ))
        else $error("table changed while chain stalled");

endmodule
